/* hdl/pdr_pkg.sv */
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants, codes, types and helpers for the palette dither converter.
// ----------------------------------------------------------------------------
package pdr_pkg;

   // Palette geometry
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_ADDR_W  = $clog2(PAL_ENTRIES);
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 8;

   // Line geometry
   localparam int MAX_LINE_WIDTH = 1024;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
   localparam int WIDTH_W        = COL_W + 1;
   localparam int LW_W           = 11;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 1'b1;

   // Output modes; bit 1 set selects packed output
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DITHER = 2'd1;
   localparam int MODE_PACKED_BIT = 1;

   localparam logic [LW_W-1:0]   LINE_WIDTH_RESET  = 11'd320;
   localparam logic [MODE_W-1:0] OUTPUT_MODE_RESET = MODE_DITHER;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Dither offsets
   localparam logic [CHAN_W-1:0] OFS_RG_EE = 8'd0;
   localparam logic [CHAN_W-1:0] OFS_RG_OE = 8'd16;
   localparam logic [CHAN_W-1:0] OFS_RG_EO = 8'd24;
   localparam logic [CHAN_W-1:0] OFS_RG_OO = 8'd8;
   localparam logic [CHAN_W-1:0] OFS_B_EE  = 8'd0;
   localparam logic [CHAN_W-1:0] OFS_B_OE  = 8'd32;
   localparam logic [CHAN_W-1:0] OFS_B_EO  = 8'd48;
   localparam logic [CHAN_W-1:0] OFS_B_OO  = 8'd16;

   // Pixel position parity carried with a pixel down the pipeline
   typedef struct packed {
      logic col_odd;
      logic row_odd;
   } pos_type;

   function automatic logic [CHAN_W-1:0] dither_rg(input pos_type pos);
      logic [CHAN_W-1:0] ofs;
      unique case ({pos.row_odd, pos.col_odd})
         2'b00:   ofs = OFS_RG_EE;
         2'b01:   ofs = OFS_RG_OE;
         2'b10:   ofs = OFS_RG_EO;
         default: ofs = OFS_RG_OO;
      endcase
      return ofs;
   endfunction

   function automatic logic [CHAN_W-1:0] dither_b(input pos_type pos);
      logic [CHAN_W-1:0] ofs;
      unique case ({pos.row_odd, pos.col_odd})
         2'b00:   ofs = OFS_B_EE;
         2'b01:   ofs = OFS_B_OE;
         2'b10:   ofs = OFS_B_EO;
         default: ofs = OFS_B_OO;
      endcase
      return ofs;
   endfunction

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] v,
                                                 input logic [CHAN_W-1:0] ofs);
      logic [CHAN_W:0] sum;
      sum = {1'b0, v} + {1'b0, ofs};
      return sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] to_rgb332(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
      return {r[7:5], g[7:5], b[7:6]};
   endfunction

endpackage

/* hdl/palette_dither_rgb332.sv */
// ----------------------------------------------------------------------------
// palette_dither_rgb332
// Indexed-color pixel converter with palette store and 2x2 ordered dither.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per accepted cycle (req_valid && !req_stall).
//   A write transaction (command 0) stores red/green/blue at index and gives
//   no response. A pixel transaction (command 1) gives exactly one rsp_color.
//   csr_write_en writes output_mode (index 0) or line_width (index 1); write
//   them only while no pixel is in flight.
// Throughput:
//   One transaction per clock sustained while req_stall stays low. An
//   accepted pixel passes the palette read at the accept edge, then the
//   formatting stage into the response register. The palette has a single
//   synchronous read port. A write is visible to a pixel accepted in the
//   very next cycle.
// Reset:
//   Synchronous; clears the pipeline, position (column 0, even row) and sets
//   output_mode to 1, line_width to 320. The palette is not cleared.
// Stall:
//   While rsp_stall holds a response, one more pixel may wait in the read
//   stage; after that req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module palette_dither_rgb332
   import pdr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [INDEX_W-1:0]     req_index,
   input  logic [CHAN_W-1:0]      req_red,
   input  logic [CHAN_W-1:0]      req_green,
   input  logic [CHAN_W-1:0]      req_blue,
   input  logic                   req_frame_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COLOR_W-1:0]     rsp_color,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [LW_W-1:0]    line_width_ff, line_width_in;
   logic               s1_valid_ff, s1_valid_in;
   pos_type            s1_pos_ff;
   logic               s1_hit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff;

   logic               req_accept;
   logic               pix_accept;
   logic               wr_accept;
   logic               s1_advance;
   logic               idx_hit;
   pos_type            cur_pos;
   logic [COLOR_W-1:0] rd_entry;
   logic [COLOR_W-1:0] fmt_color;

   // configuration registers
   always_comb begin
      mode_in       = mode_ff;
      line_width_in = line_width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OUTPUT_MODE: mode_in       = csr_wdata[MODE_W-1:0];
            CSR_LINE_WIDTH:  line_width_in = csr_wdata[LW_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= OUTPUT_MODE_RESET;
         line_width_ff <= LINE_WIDTH_RESET;
      end else begin
         mode_ff       <= mode_in;
         line_width_ff <= line_width_in;
      end
   end

   // handshake: read stage moves on when the response slot is free or taken
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign pix_accept = req_accept && (req_command == CMD_PIXEL);
   assign wr_accept  = req_accept && (req_command == CMD_WRITE);
   assign idx_hit    = 32'(req_index) < PAL_ENTRIES;

   pdr_palette_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_accept && idx_hit),
      .wr_addr (req_index[PAL_ADDR_W-1:0]),
      .wr_data ({req_blue, req_green, req_red}),
      .rd_en   (pix_accept),
      .rd_addr (req_index[PAL_ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   pdr_position u_pos (
      .clock       (clock),
      .reset       (reset),
      .advance     (pix_accept),
      .frame_start (req_frame_start),
      .line_width  (line_width_ff),
      .pos         (cur_pos)
   );

   // read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = (req_command == CMD_PIXEL);
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_pos_ff <= cur_pos;
         s1_hit_ff <= idx_hit;
      end
   end

   pdr_color_fmt u_fmt (
      .entry (rd_entry),
      .hit   (s1_hit_ff),
      .mode  (mode_ff),
      .pos   (s1_pos_ff),
      .color (fmt_color)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_color_ff <= fmt_color;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_color = rsp_color_ff;

   // a write never occupies the read stage; a pixel always does
   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (s1_valid_ff == $past(req_command == CMD_PIXEL)))
      else $error("read stage load does not match accepted command");

   // a held pixel blocks the input while the response slot is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input accepted over a blocked read stage");

   // RGB332 modes leave the upper color bits clear
   a_rgb332_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !mode_ff[MODE_PACKED_BIT]) |-> (rsp_color_ff[COLOR_W-1:CHAN_W] == '0))
      else $error("RGB332 response with upper bits set");

   // a response is only replaced after it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_color_ff)))
      else $error("stalled response changed");

endmodule

/* hdl/pdr_palette_ram.sv */
// ----------------------------------------------------------------------------
// pdr_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pdr_palette_ram
   import pdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PAL_ADDR_W-1:0] wr_addr,
   input  logic [COLOR_W-1:0]    wr_data,
   input  logic                  rd_en,
   input  logic [PAL_ADDR_W-1:0] rd_addr,
   output logic [COLOR_W-1:0]    rd_data
);

   logic [COLOR_W-1:0] store_ff [PAL_ENTRIES];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pdr_position.sv */
// ----------------------------------------------------------------------------
// pdr_position
// Pixel column/row tracker with line wrap and frame restart.
// ----------------------------------------------------------------------------
module pdr_position
   import pdr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            frame_start,
   input  logic [LW_W-1:0] line_width,
   output pos_type         pos
);

   logic [COL_W-1:0]   column_ff, column_in;
   logic               row_odd_ff, row_odd_in;
   logic [COL_W-1:0]   cur_col;
   logic               cur_row;
   logic [WIDTH_W-1:0] eff_width;
   logic [WIDTH_W-1:0] col_plus;

   always_comb begin
      priority if (line_width == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (32'(line_width) > MAX_LINE_WIDTH) begin
         eff_width = WIDTH_W'(MAX_LINE_WIDTH);
      end else begin
         eff_width = WIDTH_W'(line_width);
      end
   end

   assign cur_col  = frame_start ? '0 : column_ff;
   assign cur_row  = frame_start ? 1'b0 : row_odd_ff;
   assign col_plus = {1'b0, cur_col} + WIDTH_W'(1);

   always_comb begin
      column_in  = column_ff;
      row_odd_in = row_odd_ff;
      if (advance) begin
         // wrap also covers a column left beyond a shrunk width
         if (col_plus >= eff_width) begin
            column_in  = '0;
            row_odd_in = ~cur_row;
         end else begin
            column_in  = col_plus[COL_W-1:0];
            row_odd_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_odd_ff <= 1'b0;
      end else begin
         column_ff  <= column_in;
         row_odd_ff <= row_odd_in;
      end
   end

   assign pos.col_odd = cur_col[0];
   assign pos.row_odd = cur_row;

endmodule

/* hdl/pdr_color_fmt.sv */
// ----------------------------------------------------------------------------
// pdr_color_fmt
// Output color formatting: plain RGB332, dithered RGB332 or packed BGR.
// ----------------------------------------------------------------------------
module pdr_color_fmt
   import pdr_pkg::*;
(
   input  logic [COLOR_W-1:0] entry,
   input  logic               hit,
   input  logic [MODE_W-1:0]  mode,
   input  pos_type            pos,
   output logic [COLOR_W-1:0] color
);

   logic [COLOR_W-1:0] val;
   logic [CHAN_W-1:0]  r, g, b;
   logic [CHAN_W-1:0]  ofs_rg, ofs_b;

   // an index beyond the palette reads as zero
   assign val    = hit ? entry : '0;
   assign r      = val[CHAN_W-1:0];
   assign g      = val[2*CHAN_W-1:CHAN_W];
   assign b      = val[3*CHAN_W-1:2*CHAN_W];
   assign ofs_rg = dither_rg(pos);
   assign ofs_b  = dither_b(pos);

   always_comb begin
      priority if (mode[MODE_PACKED_BIT]) begin
         color = val;
      end else if (mode == MODE_DITHER) begin
         color = {{(COLOR_W-CHAN_W){1'b0}},
                  to_rgb332(sat_add(r, ofs_rg), sat_add(g, ofs_rg), sat_add(b, ofs_b))};
      end else begin
         color = {{(COLOR_W-CHAN_W){1'b0}}, to_rgb332(r, g, b)};
      end
   end

endmodule
